// ===== rtl/core/tfd_pkg.sv =====
// Package for the telemetry frame decoder: parser states, frame kinds,
// header and type letters, payload lengths. No dependencies.
`default_nettype none
package tfd_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DOLLAR,
        ST_TYPE,
        ST_PAYLOAD,
        ST_DECODE,
        ST_EMIT
    } parse_state_t;

    // shared conversion unit sequencer
    typedef enum logic [2:0] {
        A_IDLE,
        A_READ,
        A_CONV1,
        A_CONV2,
        A_CONV3,
        A_DONE
    } alu_state_t;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_T      = 8'h54;
    localparam logic [7:0] CH_G      = 8'h47;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_O      = 8'h4F;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_X      = 8'h58;

    localparam logic [2:0] KIND_G = 3'd0;
    localparam logic [2:0] KIND_A = 3'd1;
    localparam logic [2:0] KIND_S = 3'd2;
    localparam logic [2:0] KIND_O = 3'd3;
    localparam logic [2:0] KIND_N = 3'd4;
    localparam logic [2:0] KIND_X = 3'd5;

    localparam logic [4:0] LEN_G = 5'd14;
    localparam logic [4:0] LEN_A = 5'd6;
    localparam logic [4:0] LEN_S = 5'd7;
    localparam logic [4:0] LEN_O = 5'd14;
    localparam logic [4:0] LEN_N = 5'd6;
    localparam logic [4:0] LEN_X = 5'd6;

    // field descriptor handed from the sequencer to the arithmetic unit
    typedef enum logic [2:0] {
        OP_RAW,     // value as assembled
        OP_SPEED,   // (v*36+5)/10
        OP_ALT,     // signed /100 toward zero
        OP_RSSI,    // v*100/255
        OP_AIRSPD,  // v*100
        OP_HEAD     // +360 if negative
    } field_op_t;

    typedef struct packed {
        logic [3:0] pos;    // first payload byte
        logic [2:0] nbytes; // 1, 2 or 4
        logic       sext;   // sign-extend assembled bytes
        logic [2:0] shift;  // right shift after assembly
        logic [5:0] mask;   // mask after shift, all ones for none
        logic       use_mask;
        field_op_t  op;
    } field_desc_t;

    localparam logic [2:0] NF_G = 3'd6;
    localparam logic [2:0] NF_A = 3'd3;
    localparam logic [2:0] NF_S = 3'd7;
    localparam logic [2:0] NF_O = 3'd5;
    localparam logic [2:0] NF_N = 3'd6;
    localparam logic [2:0] NF_X = 3'd5;

    function automatic logic [2:0] num_fields(input logic [2:0] kind);
        logic [2:0] r;
        begin
            unique case (kind)
                KIND_G: r = NF_G;
                KIND_A: r = NF_A;
                KIND_S: r = NF_S;
                KIND_O: r = NF_O;
                KIND_N: r = NF_N;
                default: r = NF_X;
            endcase
            return r;
        end
    endfunction

    function automatic field_desc_t mk(input logic [3:0] pos, input logic [2:0] nb,
                                       input logic sx, input field_op_t op);
        field_desc_t d;
        begin
            d.pos = pos; d.nbytes = nb; d.sext = sx; d.shift = 3'd0;
            d.mask = 6'h3F; d.use_mask = 1'b0; d.op = op;
            return d;
        end
    endfunction

    function automatic field_desc_t field_desc(input logic [2:0] kind,
                                               input logic [2:0] id);
        field_desc_t d;
        begin
            d = mk(4'd0, 3'd1, 1'b0, OP_RAW);
            unique case (kind)
                KIND_G: begin
                    unique case (id)
                        3'd0: d = mk(4'd0, 3'd4, 1'b0, OP_RAW);
                        3'd1: d = mk(4'd4, 3'd4, 1'b0, OP_RAW);
                        3'd2: d = mk(4'd8, 3'd1, 1'b0, OP_SPEED);
                        3'd3: d = mk(4'd9, 3'd4, 1'b1, OP_ALT);
                        3'd4: begin
                            d = mk(4'd13, 3'd1, 1'b0, OP_RAW);
                            d.shift = 3'd2;
                        end
                        default: begin
                            d = mk(4'd13, 3'd1, 1'b0, OP_RAW);
                            d.mask = 6'h03; d.use_mask = 1'b1;
                        end
                    endcase
                end
                KIND_A: begin
                    unique case (id)
                        3'd0: d = mk(4'd0, 3'd2, 1'b1, OP_RAW);
                        3'd1: d = mk(4'd2, 3'd2, 1'b1, OP_RAW);
                        default: d = mk(4'd4, 3'd2, 1'b1, OP_HEAD);
                    endcase
                end
                KIND_S: begin
                    unique case (id)
                        3'd0: d = mk(4'd0, 3'd2, 1'b0, OP_RAW);
                        3'd1: d = mk(4'd2, 3'd2, 1'b0, OP_RAW);
                        3'd2: d = mk(4'd4, 3'd1, 1'b0, OP_RSSI);
                        3'd3: d = mk(4'd5, 3'd1, 1'b0, OP_AIRSPD);
                        3'd4: begin
                            d = mk(4'd6, 3'd1, 1'b0, OP_RAW);
                            d.mask = 6'h01; d.use_mask = 1'b1;
                        end
                        3'd5: begin
                            d = mk(4'd6, 3'd1, 1'b0, OP_RAW);
                            d.shift = 3'd1; d.mask = 6'h01; d.use_mask = 1'b1;
                        end
                        default: begin
                            d = mk(4'd6, 3'd1, 1'b0, OP_RAW);
                            d.shift = 3'd2; d.mask = 6'h3F; d.use_mask = 1'b1;
                        end
                    endcase
                end
                KIND_O: begin
                    unique case (id)
                        3'd0: d = mk(4'd0, 3'd4, 1'b0, OP_RAW);
                        3'd1: d = mk(4'd4, 3'd4, 1'b0, OP_RAW);
                        3'd2: d = mk(4'd8, 3'd4, 1'b0, OP_RAW);
                        3'd3: d = mk(4'd12, 3'd1, 1'b1, OP_RAW);
                        default: d = mk(4'd13, 3'd1, 1'b1, OP_RAW);
                    endcase
                end
                KIND_N: d = mk(4'(id), 3'd1, 1'b0, OP_RAW);
                default: begin
                    if (id == 3'd0) d = mk(4'd0, 3'd2, 1'b0, OP_RAW);
                    else d = mk(4'(id) + 4'd1, 3'd1, 1'b0, OP_RAW);
                end
            endcase
            return d;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/telemetry_frame_decoder.sv =====
// Telemetry frame decoder top level; depends on tfd_pkg and tfd_seq.
// Input is ready while parsing: header, type and payload bytes one per cycle.
// After a good checksum byte the input stalls while each field is read (1, 2 or 4
// bytes) and converted in the shared unit, then sent as one output transaction.
// A bad checksum gives one error transaction, offered in the next cycle.
// Synchronous active-low reset clears parser state and frame counters.
`default_nettype none
module telemetry_frame_decoder
    import tfd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 14,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  s_axis_tdata,  // rx_byte
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    // value[31:0], good_frames[47:32], bad_frames[63:48]
    output      logic [63:0] m_axis_tdata,
    // status[0], frame_kind[3:1], item_id[6:4]
    output      logic [6:0]  m_axis_tuser,
    output      logic        m_axis_tlast,  // last_of_frame
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready
);
    tfd_seq #(.MAX_PAYLOAD(MAX_PAYLOAD), .COUNT_BITS(COUNT_BITS)) u_seq (
        .aclk(aclk), .aresetn(aresetn),
        .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready)
    );
endmodule
`default_nettype wire

// ===== rtl/core/tfd_ram.sv =====
// Generic single-port write, registered-read RAM.
// No dependencies.
`default_nettype none
module tfd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 14
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output      logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rd_data <= mem[rd_addr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/tfd_alu.sv =====
// Shared conversion unit: assembles a field byte by byte, then applies
// one conversion step per cycle (multiply by constant, shift, fix-up).
// Depends on tfd_pkg.
`default_nettype none
module tfd_alu
    import tfd_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire field_desc_t desc,
    input  wire logic [7:0]  rd_data,   // RAM byte, addressed by rd_addr in the cycle before
    output      logic [3:0]  rd_addr,
    output      logic        done,
    output      logic [31:0] result
);
    alu_state_t  st_reg, st_next;
    field_desc_t d_reg;
    logic [2:0]  cnt_reg;         // bytes requested
    logic [2:0]  got_reg;         // bytes received
    logic [31:0] acc_reg, acc_next;
    logic [63:0] prod_reg, prod_next;
    logic [63:0] p;
    logic [31:0] sx;

    assign rd_addr = d_reg.pos + {1'b0, cnt_reg};
    assign done    = (st_reg == A_DONE);
    assign result  = acc_reg;

    always_comb begin
        unique case (d_reg.nbytes)
            3'd1: sx = d_reg.sext ? {{24{acc_reg[7]}}, acc_reg[7:0]} : {24'd0, acc_reg[7:0]};
            3'd2: sx = d_reg.sext ? {{16{acc_reg[15]}}, acc_reg[15:0]}
                                  : {16'd0, acc_reg[15:0]};
            default: sx = acc_reg;
        endcase
    end

    always_comb begin
        st_next   = st_reg;
        acc_next  = acc_reg;
        prod_next = prod_reg;
        p         = 64'd0;
        unique case (st_reg)
            A_IDLE: if (start) st_next = A_READ;
            A_READ: begin
                if (got_reg == d_reg.nbytes) st_next = A_CONV1;
            end
            A_CONV1: begin
                acc_next = sx;
                if (d_reg.use_mask || d_reg.shift != 3'd0)
                    acc_next = (sx >> d_reg.shift) & (d_reg.use_mask ? {26'd0, d_reg.mask}
                                                                     : 32'hFFFF_FFFF);
                unique case (d_reg.op)
                    OP_SPEED:  prod_next = 64'(sx) * 64'd36 + 64'd5;
                    OP_RSSI:   prod_next = 64'(sx) * 64'd100;
                    OP_AIRSPD: prod_next = 64'(sx) * 64'd100;
                    OP_ALT:    prod_next = {32'd0, sx[31] ? (32'd0 - sx) : sx};
                    default:   prod_next = 64'd0;
                endcase
                if (d_reg.op == OP_HEAD && sx[31]) acc_next = sx + 32'd360;
                st_next = A_CONV2;
            end
            A_CONV2: begin
                // reciprocal multiply for the divide steps
                unique case (d_reg.op)
                    OP_SPEED: prod_next = (64'(prod_reg[31:0]) * 64'd52429) >> 19;      // /10
                    OP_RSSI:  prod_next = (64'(prod_reg[31:0]) * 64'd32897) >> 23;      // /255
                    OP_ALT:   prod_next = (64'(prod_reg[31:0]) * 64'd2748779070) >> 38; // /100
                    default:  prod_next = prod_reg;
                endcase
                st_next = A_CONV3;
            end
            A_CONV3: begin
                p = prod_reg;
                unique case (d_reg.op)
                    OP_SPEED, OP_RSSI, OP_AIRSPD: acc_next = p[31:0];
                    OP_ALT: acc_next = sx[31] ? (32'd0 - p[31:0]) : p[31:0];
                    default: ;
                endcase
                st_next = A_DONE;
            end
            A_DONE: st_next = A_IDLE;
            default: st_next = A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= A_IDLE;
            cnt_reg <= 3'd0;
            got_reg <= 3'd0;
        end else begin
            st_reg <= st_next;
            if (st_reg == A_IDLE && start) begin
                d_reg   <= desc;
                cnt_reg <= 3'd0;
                got_reg <= 3'd0;
                acc_reg <= 32'd0;
            end else if (st_reg == A_READ) begin
                if (cnt_reg != d_reg.nbytes) cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg != 3'd0 && got_reg != d_reg.nbytes) begin
                    acc_reg <= acc_reg | (32'(rd_data) << {got_reg[1:0], 3'b000});
                    got_reg <= got_reg + 3'd1;
                end
            end else begin
                acc_reg <= acc_next;
            end
            prod_reg <= prod_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/tfd_seq.sv =====
// Frame parser and result sequencer: header hunt, payload capture with
// XOR check, then one field at a time through the shared unit.
// Depends on tfd_pkg, tfd_ram, tfd_alu.
`default_nettype none
module tfd_seq
    import tfd_pkg::*;
#(
    parameter int MAX_PAYLOAD = 14,
    parameter int COUNT_BITS  = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic [7:0]  s_axis_tdata,  // rx_byte
    input  wire logic        s_axis_tvalid,
    output      logic        s_axis_tready,
    output      logic [63:0] m_axis_tdata,  // value, good_frames, bad_frames
    output      logic [6:0]  m_axis_tuser,  // status, frame_kind, item_id
    output      logic        m_axis_tlast,
    output      logic        m_axis_tvalid,
    input  wire logic        m_axis_tready
);
    localparam int AW = $clog2(MAX_PAYLOAD);

    parse_state_t st_reg, st_next;
    logic [2:0]  kind_reg;
    logic [4:0]  len_reg;
    logic [4:0]  idx_reg;
    logic [7:0]  xor_reg;
    logic [COUNT_BITS-1:0] good_reg, bad_reg;
    logic [2:0]  id_reg;
    logic        err_reg;
    logic        alu_busy_reg;
    logic [31:0] val_reg;
    logic        acc;
    logic        start;
    logic        alu_done;
    logic [31:0] alu_res;
    logic [3:0]  alu_addr;
    logic [7:0]  rd_data;
    logic [2:0]  tkind;
    logic        tok;

    assign acc = s_axis_tvalid && s_axis_tready;

    always_comb begin
        tok = 1'b1;
        tkind = KIND_G;
        unique case (s_axis_tdata)
            CH_G: tkind = KIND_G;
            CH_A: tkind = KIND_A;
            CH_S: tkind = KIND_S;
            CH_O: tkind = KIND_O;
            CH_N: tkind = KIND_N;
            CH_X: tkind = KIND_X;
            default: tok = 1'b0;
        endcase
    end

    // checksum byte is not stored
    tfd_ram #(.WIDTH(8), .DEPTH(MAX_PAYLOAD)) u_ram (
        .aclk(aclk),
        .wr_en(acc && st_reg == ST_PAYLOAD && idx_reg < len_reg),
        .wr_addr(idx_reg[AW-1:0]),
        .wr_data(s_axis_tdata),
        .rd_addr(AW'(alu_addr)),
        .rd_data(rd_data)
    );

    assign start = (st_reg == ST_DECODE) && !alu_busy_reg;

    tfd_alu u_alu (
        .aclk(aclk), .aresetn(aresetn), .start(start),
        .desc(field_desc(kind_reg, id_reg)), .rd_data(rd_data),
        .rd_addr(alu_addr), .done(alu_done), .result(alu_res)
    );

    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:   if (acc) st_next = (s_axis_tdata == CH_DOLLAR) ? ST_DOLLAR : ST_IDLE;
            ST_DOLLAR: if (acc) st_next = (s_axis_tdata == CH_T) ? ST_TYPE : ST_IDLE;
            ST_TYPE:   if (acc) st_next = tok ? ST_PAYLOAD : ST_IDLE;
            ST_PAYLOAD:
                if (acc && idx_reg >= len_reg)
                    st_next = ((xor_reg ^ s_axis_tdata) == 8'd0) ? ST_DECODE : ST_EMIT;
            ST_DECODE: if (alu_done) st_next = ST_EMIT;
            ST_EMIT:
                if (m_axis_tready)
                    st_next = (err_reg || id_reg == num_fields(kind_reg) - 3'd1)
                            ? ST_IDLE : ST_DECODE;
            default: st_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (st_reg == ST_IDLE) || (st_reg == ST_DOLLAR) ||
                        (st_reg == ST_TYPE) || (st_reg == ST_PAYLOAD);
        m_axis_tvalid = (st_reg == ST_EMIT);
        m_axis_tlast  = err_reg || (id_reg == num_fields(kind_reg) - 3'd1);
        m_axis_tdata  = {16'(bad_reg), 16'(good_reg), err_reg ? 32'd0 : val_reg};
        m_axis_tuser  = {err_reg ? 3'd0 : id_reg, kind_reg, err_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg       <= ST_IDLE;
            kind_reg     <= 3'd0;
            len_reg      <= 5'd0;
            idx_reg      <= 5'd0;
            xor_reg      <= 8'd0;
            good_reg     <= '0;
            bad_reg      <= '0;
            id_reg       <= 3'd0;
            err_reg      <= 1'b0;
            alu_busy_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            if (start) alu_busy_reg <= 1'b1;
            if (alu_done) begin
                alu_busy_reg <= 1'b0;
                val_reg      <= alu_res;
            end
            if (acc && st_reg == ST_TYPE) begin
                idx_reg <= 5'd0;
                xor_reg <= 8'd0;
                if (tok) begin
                    kind_reg <= tkind;
                    unique case (tkind)
                        KIND_G: len_reg <= LEN_G;
                        KIND_A: len_reg <= LEN_A;
                        KIND_S: len_reg <= LEN_S;
                        KIND_O: len_reg <= LEN_O;
                        KIND_N: len_reg <= LEN_N;
                        default: len_reg <= LEN_X;
                    endcase
                end
            end
            if (acc && st_reg == ST_PAYLOAD) begin
                xor_reg <= xor_reg ^ s_axis_tdata;
                if (idx_reg >= len_reg) begin
                    id_reg <= 3'd0;
                    if ((xor_reg ^ s_axis_tdata) == 8'd0) begin
                        err_reg  <= 1'b0;
                        good_reg <= good_reg + COUNT_BITS'(1);
                    end else begin
                        err_reg <= 1'b1;
                        bad_reg <= bad_reg + COUNT_BITS'(1);
                    end
                end else begin
                    idx_reg <= idx_reg + 5'd1;
                end
            end
            if (st_reg == ST_EMIT && m_axis_tready) id_reg <= id_reg + 3'd1;
        end
    end
endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for telemetry_frame_decoder: drives telemetry byte
// streams, predicts the decoded field transactions and compares them.
// Depends on tfd_pkg and the decoder RTL only.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
    import tfd_pkg::*;

    localparam int LIMIT_CYCLES = 400000;

    typedef struct {
        logic        status;
        logic [2:0]  kind;
        logic [2:0]  id;
        logic [31:0] value;
        logic        last;
        logic [15:0] good;
        logic [15:0] bad;
    } field_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic [7:0]  s_axis_tdata = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    wire  [63:0] m_axis_tdata;
    wire  [6:0]  m_axis_tuser;
    wire         m_axis_tlast;
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;

    telemetry_frame_decoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tdata  (s_axis_tdata),   // rx_byte
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // value, good_frames, bad_frames
        .m_axis_tuser  (m_axis_tuser),   // status, frame_kind, item_id
        .m_axis_tlast  (m_axis_tlast),   // last_of_frame
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    always #5 aclk = ~aclk;

    field_t       fields_due[$];
    int           fail_count = 0;
    int           cycle_count = 0;
    bit           idling_on = 1'b1;
    int           hold_cycles = 0;
    int           rx_stall = 0;

    // decoder shadow state
    parse_state_t p_state = ST_IDLE;
    logic [2:0]   p_kind = '0;
    logic [4:0]   p_len = '0;
    logic [4:0]   p_index = '0;
    logic [7:0]   p_fold = '0;
    logic [7:0]   p_store [14];
    logic [15:0]  good_total = '0;
    logic [15:0]  bad_total = '0;

    function automatic logic [31:0] rd8(int pos);
        return {24'd0, p_store[pos]};
    endfunction

    function automatic logic [31:0] rd16(int pos);
        return rd8(pos) | (rd8(pos + 1) << 8);
    endfunction

    function automatic logic [31:0] rd32(int pos);
        return rd16(pos) | (rd16(pos + 2) << 16);
    endfunction

    function automatic logic [31:0] sext16(logic [31:0] v);
        return {{16{v[15]}}, v[15:0]};
    endfunction

    function automatic logic [31:0] sext8(logic [31:0] v);
        return {{24{v[7]}}, v[7:0]};
    endfunction

    function automatic void push_field(logic status, logic [2:0] id, logic [31:0] value);
        field_t f;
        f.status = status;
        f.kind = p_kind;
        f.id = id;
        f.value = value;
        f.last = 1'b0;
        f.good = good_total;
        f.bad = bad_total;
        fields_due.push_back(f);
    endfunction

    function automatic void decode_frame();
        logic [31:0] b;
        logic [31:0] h;
        case (p_kind)
            KIND_G: begin
                push_field(1'b0, 3'd0, rd32(0));
                push_field(1'b0, 3'd1, rd32(4));
                push_field(1'b0, 3'd2, (rd8(8) * 36 + 5) / 10);
                push_field(1'b0, 3'd3, $signed(rd32(9)) / 100);
                b = rd8(13);
                push_field(1'b0, 3'd4, b >> 2);
                push_field(1'b0, 3'd5, b & 32'd3);
            end
            KIND_A: begin
                push_field(1'b0, 3'd0, sext16(rd16(0)));
                push_field(1'b0, 3'd1, sext16(rd16(2)));
                h = sext16(rd16(4));
                if (h[31]) h = h + 32'd360;
                push_field(1'b0, 3'd2, h);
            end
            KIND_S: begin
                push_field(1'b0, 3'd0, rd16(0));
                push_field(1'b0, 3'd1, rd16(2));
                push_field(1'b0, 3'd2, (rd8(4) * 100) / 255);
                push_field(1'b0, 3'd3, rd8(5) * 100);
                b = rd8(6);
                push_field(1'b0, 3'd4, b & 32'd1);
                push_field(1'b0, 3'd5, (b >> 1) & 32'd1);
                push_field(1'b0, 3'd6, (b >> 2) & 32'h3F);
            end
            KIND_O: begin
                push_field(1'b0, 3'd0, rd32(0));
                push_field(1'b0, 3'd1, rd32(4));
                push_field(1'b0, 3'd2, rd32(8));
                push_field(1'b0, 3'd3, sext8(rd8(12)));
                push_field(1'b0, 3'd4, sext8(rd8(13)));
            end
            KIND_N: begin
                for (int i = 0; i < 6; i++) push_field(1'b0, 3'(i), rd8(i));
            end
            default: begin
                push_field(1'b0, 3'd0, rd16(0));
                for (int i = 0; i < 4; i++) push_field(1'b0, 3'(i + 1), rd8(2 + i));
            end
        endcase
        fields_due[$].last = 1'b1;
    endfunction

    // advance the shadow parser by one accepted byte
    function automatic void track_byte(logic [7:0] c);
        case (p_state)
            ST_IDLE:   p_state = (c == CH_DOLLAR) ? ST_DOLLAR : ST_IDLE;
            ST_DOLLAR: p_state = (c == CH_T) ? ST_TYPE : ST_IDLE;
            ST_TYPE: begin
                p_index = '0;
                p_fold = '0;
                p_state = ST_PAYLOAD;
                case (c)
                    CH_G: begin p_kind = KIND_G; p_len = LEN_G; end
                    CH_A: begin p_kind = KIND_A; p_len = LEN_A; end
                    CH_S: begin p_kind = KIND_S; p_len = LEN_S; end
                    CH_O: begin p_kind = KIND_O; p_len = LEN_O; end
                    CH_N: begin p_kind = KIND_N; p_len = LEN_N; end
                    CH_X: begin p_kind = KIND_X; p_len = LEN_X; end
                    default: p_state = ST_IDLE;
                endcase
            end
            ST_PAYLOAD: begin
                p_fold = p_fold ^ c;
                if (p_index >= p_len) begin
                    p_state = ST_IDLE;
                    if (p_fold == 8'd0) begin
                        good_total = good_total + 16'd1;
                        decode_frame();
                    end else begin
                        bad_total = bad_total + 16'd1;
                        push_field(1'b1, 3'd0, 32'd0);
                        fields_due[$].last = 1'b1;
                    end
                end else begin
                    p_store[p_index] = c;
                    p_index = p_index + 5'd1;
                end
            end
            default: p_state = ST_IDLE;
        endcase
    endfunction

    task automatic send_byte(logic [7:0] c);
        int gap;
        gap = idling_on ? $urandom_range(0, 7) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= c;
        do @(posedge aclk); while (!s_axis_tready);
        track_byte(c);
    endtask

    function automatic logic [7:0] letter_of(logic [2:0] kind);
        case (kind)
            KIND_G: return CH_G;
            KIND_A: return CH_A;
            KIND_S: return CH_S;
            KIND_O: return CH_O;
            KIND_N: return CH_N;
            default: return CH_X;
        endcase
    endfunction

    function automatic int len_of(logic [2:0] kind);
        case (kind)
            KIND_G: return int'(LEN_G);
            KIND_A: return int'(LEN_A);
            KIND_S: return int'(LEN_S);
            KIND_O: return int'(LEN_O);
            KIND_N: return int'(LEN_N);
            default: return int'(LEN_X);
        endcase
    endfunction

    // fill: 0 random, 1 all zeros, 2 all ones, 3 top bit only
    task automatic send_frame(logic [2:0] kind, int fill, bit corrupt);
        logic [7:0] b;
        logic [7:0] sum;
        sum = '0;
        send_byte(CH_DOLLAR);
        send_byte(CH_T);
        send_byte(letter_of(kind));
        for (int i = 0; i < len_of(kind); i++) begin
            case (fill)
                1: b = 8'h00;
                2: b = 8'hFF;
                3: b = 8'h80;
                default: b = 8'($urandom_range(0, 255));
            endcase
            sum = sum ^ b;
            send_byte(b);
        end
        if (corrupt) sum = sum ^ 8'($urandom_range(1, 255));
        send_byte(sum);
    endtask

    task automatic test_each_kind_extremes();
        for (int k = 0; k < 6; k++) begin
            send_frame(3'(k), 2, 1'b0);
        end
        // negative values on the signed fields (every byte 8'h80)
        send_frame(KIND_G, 3, 1'b0);
        send_frame(KIND_A, 3, 1'b0);
        send_frame(KIND_O, 3, 1'b0);
    endtask

    task automatic test_header_faults();
        send_byte(CH_DOLLAR);
        send_byte(CH_DOLLAR);   // second dollar breaks the header
        send_byte(CH_T);
        send_byte(CH_DOLLAR);
        send_byte(8'h00);
        send_byte(CH_DOLLAR);
        send_byte(CH_T);
        send_byte(8'h5A);       // unknown type letter
        send_frame(KIND_A, 0, 1'b0);
    endtask

    task automatic test_bad_checksum();
        send_frame(KIND_G, 0, 1'b1);
        send_frame(KIND_S, 0, 1'b1);
    endtask

    task automatic test_random_stream(int n_frames);
        int pick;
        for (int f = 0; f < n_frames; f++) begin
            if (f % 4 == 1) idling_on = 1'b0;
            if (f % 4 == 3) idling_on = 1'b1;
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                send_frame(3'($urandom_range(0, 5)), 0, 1'b0);
            end else if (pick == 7) begin
                send_frame(3'($urandom_range(0, 5)), 0, 1'b1);
            end else begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
                if ($urandom_range(0, 1)) begin
                    send_byte(CH_DOLLAR);
                    send_byte(CH_T);
                    send_byte(8'($urandom_range(0, 255)));
                end
            end
        end
        idling_on = 1'b1;
    endtask

    task automatic test_output_backpressure();
        hold_cycles = 400;
        send_frame(KIND_S, 0, 1'b0);
        send_frame(KIND_X, 0, 1'b0);
    endtask

    // result side: random stalls, long hold-off on request, field compare
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (fields_due.size() == 0) begin
                    $display("%0t: unexpected transaction, actual %h user %h last %b", $time,
                             m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    fail_count++;
                end else begin
                    field_t e;
                    e = fields_due.pop_front();
                    if (m_axis_tuser[0] !== e.status || m_axis_tuser[3:1] !== e.kind ||
                        m_axis_tuser[6:4] !== e.id || m_axis_tdata[31:0] !== e.value ||
                        m_axis_tdata[47:32] !== e.good || m_axis_tdata[63:48] !== e.bad ||
                        m_axis_tlast !== e.last) begin
                        $display("%0t: mismatch expected st %b kind %0d id %0d val %h %s",
                                 $time, e.status, e.kind, e.id, e.value, "");
                        $display("%0t:          expected good %0d bad %0d last %b",
                                 $time, e.good, e.bad, e.last);
                        $display("%0t:          actual st %b kind %0d id %0d val %h",
                                 $time, m_axis_tuser[0], m_axis_tuser[3:1], m_axis_tuser[6:4],
                                 m_axis_tdata[31:0]);
                        $display("%0t:          actual good %0d bad %0d last %b",
                                 $time, m_axis_tdata[47:32], m_axis_tdata[63:48],
                                 m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_axis_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_axis_tready <= 1'b0;
            end else if (m_axis_tvalid && m_axis_tready) begin
                rx_stall = idling_on ? $urandom_range(0, 7) : 0;
                m_axis_tready <= (rx_stall == 0);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_each_kind_extremes();
        test_header_faults();
        test_bad_checksum();
        test_output_backpressure();
        test_random_stream(3);
        s_axis_tvalid <= 1'b0;
        while (fields_due.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
`default_nettype wire

// ===== telemetry_frame_decoder.f =====
rtl/core/tfd_pkg.sv
rtl/core/tfd_ram.sv
rtl/core/tfd_alu.sv
rtl/core/tfd_seq.sv
rtl/core/telemetry_frame_decoder.sv
tb/testbench.sv
